// ===== hdl/plti_pkg.sv =====
// Shared constants, codes and control types for the piecewise-linear table interpolator.
package plti_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int ENTRY_IDX_W = 6;
    localparam int DATA_W      = 32;
    localparam int CNT_W       = 7;
    localparam int DIV_STEPS   = DATA_W + 1;
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef struct packed {
        logic             load_we;
        logic             q_capture;
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
        logic             cmp_en;
        logic             cmp_first;
        logic             cmp_last;
        logic             prep1;
        logic             prep2;
        logic             mul0;
        logic             mul1;
        logic             div_init;
        logic             div_step;
        logic             out_load;
    } t_cmd;

    typedef struct packed {
        logic need_interp;
        logic out_busy;
    } t_status;

endpackage

// ===== hdl/plti_if.sv =====
// Valid/ready channel interfaces for the input and result beats.
interface plti_in_if import plti_pkg::*;;
    logic                     valid;
    logic                     ready;
    logic                     op;
    logic [ENTRY_IDX_W-1:0]   entry_index;
    logic signed [DATA_W-1:0] entry_key;
    logic signed [DATA_W-1:0] entry_value;
    logic signed [DATA_W-1:0] query_key;

    modport source (output valid, op, entry_index, entry_key, entry_value, query_key,
                    input ready);
    modport sink   (input valid, op, entry_index, entry_key, entry_value, query_key,
                    output ready);
endinterface

interface plti_out_if import plti_pkg::*;;
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] result_value;
    logic                     below_range;
    logic                     above_range;

    modport source (output valid, result_value, below_range, above_range, input ready);
    modport sink   (input valid, result_value, below_range, above_range, output ready);
endinterface

// ===== hdl/plti_ctrl.sv =====
// Sequencer: beat acceptance, table scan, multiply and divide stepping, result hand-off.
module plti_ctrl import plti_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CNT_W-1:0] i_cfg_wdata,
    plti_in_if.sink          i_in,
    input  t_status          i_status,
    output t_cmd             o_cmd
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_SCAN   = 4'd1;
    localparam logic [3:0] S_DECIDE = 4'd2;
    localparam logic [3:0] S_PREP1  = 4'd3;
    localparam logic [3:0] S_PREP2  = 4'd4;
    localparam logic [3:0] S_MUL0   = 4'd5;
    localparam logic [3:0] S_MUL1   = 4'd6;
    localparam logic [3:0] S_DIVI   = 4'd7;
    localparam logic [3:0] S_DIV    = 4'd8;
    localparam logic [3:0] S_FIN    = 4'd9;

    logic [3:0]           r_state, n_state;
    logic [CNT_W-1:0]     r_count;
    logic [IDX_W-1:0]     r_idx, n_idx;
    logic [DIV_CNT_W-1:0] r_div_cnt, n_div_cnt;
    logic [IDX_W-1:0]     last_idx;

    // live count: zero acts as one, above depth acts as depth
    always_comb begin
        if (r_count == '0) begin
            last_idx = '0;
        end else if (int'(r_count) > TABLE_DEPTH) begin
            last_idx = IDX_W'(TABLE_DEPTH - 1);
        end else begin
            last_idx = IDX_W'(r_count - CNT_W'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= CNT_W'(1);
            r_idx     <= '0;
            r_div_cnt <= '0;
        end else begin
            r_state   <= n_state;
            r_idx     <= n_idx;
            r_div_cnt <= n_div_cnt;
            if (i_cfg_we) begin
                r_count <= i_cfg_wdata;
            end
        end
    end

    always_comb begin
        n_state    = r_state;
        n_idx      = r_idx;
        n_div_cnt  = r_div_cnt;
        o_cmd      = '0;
        i_in.ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                i_in.ready = 1'b1;
                if (i_in.valid) begin
                    if (i_in.op == OP_QUERY) begin
                        o_cmd.q_capture = 1'b1;
                        o_cmd.rd_en     = 1'b1;
                        o_cmd.rd_addr   = '0;
                        n_idx           = '0;
                        n_state         = S_SCAN;
                    end else begin
                        o_cmd.load_we = 1'b1;
                    end
                end
            end
            S_SCAN: begin
                o_cmd.cmp_en    = 1'b1;
                o_cmd.cmp_first = (r_idx == '0);
                o_cmd.cmp_last  = (r_idx == last_idx);
                if (r_idx == last_idx) begin
                    n_state = S_DECIDE;
                end else begin
                    o_cmd.rd_en   = 1'b1;
                    o_cmd.rd_addr = r_idx + IDX_W'(1);
                    n_idx         = r_idx + IDX_W'(1);
                end
            end
            S_DECIDE: begin
                n_state = i_status.need_interp ? S_PREP1 : S_FIN;
            end
            S_PREP1: begin
                o_cmd.prep1 = 1'b1;
                n_state     = S_PREP2;
            end
            S_PREP2: begin
                o_cmd.prep2 = 1'b1;
                n_state     = S_MUL0;
            end
            S_MUL0: begin
                o_cmd.mul0 = 1'b1;
                n_state    = S_MUL1;
            end
            S_MUL1: begin
                o_cmd.mul1 = 1'b1;
                n_state    = S_DIVI;
            end
            S_DIVI: begin
                o_cmd.div_init = 1'b1;
                n_div_cnt      = '0;
                n_state        = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_div_cnt      = r_div_cnt + DIV_CNT_W'(1);
                if (r_div_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (!i_status.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ===== hdl/plti_dp.sv =====
// Datapath: table memory, bracket capture, multiplier, restoring divider, output register.
module plti_dp import plti_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_cmd                     i_cmd,
    input  logic [ENTRY_IDX_W-1:0]   i_entry_index,
    input  logic signed [DATA_W-1:0] i_entry_key,
    input  logic signed [DATA_W-1:0] i_entry_value,
    input  logic signed [DATA_W-1:0] i_query_key,
    output t_status                  o_status,
    plti_out_if.source               o_out
);

    logic [2*DATA_W-1:0] mem [TABLE_DEPTH];

    logic signed [DATA_W-1:0] r_rd_key, r_rd_val;
    logic signed [DATA_W-1:0] r_q;
    logic                     r_below, r_match, r_have_lo, r_have_hi;
    logic signed [DATA_W-1:0] r_val0, r_match_val, r_last_val;
    logic signed [DATA_W-1:0] r_xl, r_yl, r_xh, r_yh;
    logic signed [DATA_W:0]   r_dy;
    logic [DATA_W-1:0]        r_dq, r_dx;
    logic                     r_neg;
    logic [DATA_W:0]          r_mag;
    logic [2*DATA_W-1:0]      r_prod;
    logic [DATA_W-1:0]        r_rem;
    logic [DATA_W:0]          r_dvd;
    logic [DATA_W:0]          r_quo;
    logic                     r_out_valid;
    logic signed [DATA_W-1:0] r_out_val;
    logic                     r_out_below, r_out_above;

    logic [DATA_W+16:0]       pp;
    logic [DATA_W+1:0]        trial;
    logic signed [DATA_W+1:0] sum;
    logic signed [DATA_W-1:0] interp_val;
    logic                     need_interp;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_we) begin
            mem[IDX_W'(i_entry_index)] <= {i_entry_key, i_entry_value};
        end
        if (i_cmd.rd_en) begin
            r_rd_key <= mem[i_cmd.rd_addr][2*DATA_W-1:DATA_W];
            r_rd_val <= mem[i_cmd.rd_addr][DATA_W-1:0];
        end
    end

    assign need_interp = !r_below && !r_match && r_have_lo && r_have_hi;

    // bracket search flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_below   <= 1'b0;
            r_match   <= 1'b0;
            r_have_lo <= 1'b0;
            r_have_hi <= 1'b0;
        end else if (i_cmd.q_capture) begin
            r_below   <= 1'b0;
            r_match   <= 1'b0;
            r_have_lo <= 1'b0;
            r_have_hi <= 1'b0;
        end else if (i_cmd.cmp_en) begin
            if (i_cmd.cmp_first && (r_q < r_rd_key)) begin
                r_below <= 1'b1;
            end
            if (r_rd_key == r_q) begin
                r_match <= 1'b1;
            end
            if (r_rd_key < r_q) begin
                r_have_lo <= 1'b1;
            end
            if (r_rd_key > r_q) begin
                r_have_hi <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.q_capture) begin
            r_q <= i_query_key;
        end
        if (i_cmd.cmp_en) begin
            if (i_cmd.cmp_first) begin
                r_val0 <= r_rd_val;
            end
            if (i_cmd.cmp_last) begin
                r_last_val <= r_rd_val;
            end
            if ((r_rd_key == r_q) && !r_match) begin
                r_match_val <= r_rd_val;
            end
            if (r_rd_key < r_q) begin
                r_xl <= r_rd_key;
                r_yl <= r_rd_val;
            end
            if ((r_rd_key > r_q) && !r_have_hi) begin
                r_xh <= r_rd_key;
                r_yh <= r_rd_val;
            end
        end
    end

    // |dy| * dq in two 16-bit halves, then dq < dx bounds the quotient to DATA_W+1 bits
    assign pp    = r_mag * (i_cmd.mul1 ? r_dq[DATA_W-1:16] : r_dq[15:0]);
    assign trial = {1'b0, r_rem, r_dvd[DATA_W]} - {2'b00, r_dx};

    always_ff @(posedge i_clk) begin
        if (i_cmd.prep1) begin
            r_dy <= {r_yh[DATA_W-1], r_yh} - {r_yl[DATA_W-1], r_yl};
            r_dq <= DATA_W'({r_q[DATA_W-1], r_q} - {r_xl[DATA_W-1], r_xl});
            r_dx <= DATA_W'({r_xh[DATA_W-1], r_xh} - {r_xl[DATA_W-1], r_xl});
        end
        if (i_cmd.prep2) begin
            r_neg <= r_dy[DATA_W];
            r_mag <= r_dy[DATA_W] ? (DATA_W+1)'(-r_dy) : r_dy;
        end
        if (i_cmd.mul0) begin
            r_prod <= {{(DATA_W-17){1'b0}}, pp};
        end
        if (i_cmd.mul1) begin
            r_prod <= r_prod + {pp[DATA_W+15:0], 16'b0};
        end
        if (i_cmd.div_init) begin
            r_rem <= {1'b0, r_prod[2*DATA_W-1:DATA_W+1]};
            r_dvd <= r_prod[DATA_W:0];
            r_quo <= '0;
        end
        if (i_cmd.div_step) begin
            if (!trial[DATA_W+1]) begin
                r_rem <= trial[DATA_W-1:0];
            end else begin
                r_rem <= {r_rem[DATA_W-2:0], r_dvd[DATA_W]};
            end
            r_dvd <= {r_dvd[DATA_W-1:0], 1'b0};
            r_quo <= {r_quo[DATA_W-1:0], ~trial[DATA_W+1]};
        end
    end

    always_comb begin
        if (r_neg) begin
            sum = {{2{r_yl[DATA_W-1]}}, r_yl} - {1'b0, r_quo};
        end else begin
            sum = {{2{r_yl[DATA_W-1]}}, r_yl} + {1'b0, r_quo};
        end
        if (sum[DATA_W+1:DATA_W-1] == 3'b000 || sum[DATA_W+1:DATA_W-1] == 3'b111) begin
            interp_val = sum[DATA_W-1:0];
        end else if (sum[DATA_W+1]) begin
            interp_val = {1'b1, {(DATA_W-1){1'b0}}};
        end else begin
            interp_val = {1'b0, {(DATA_W-1){1'b1}}};
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_below <= r_below;
            r_out_above <= !r_below && !r_match && !(r_have_lo && r_have_hi);
            if (r_below) begin
                r_out_val <= r_val0;
            end else if (r_match) begin
                r_out_val <= r_match_val;
            end else if (!(r_have_lo && r_have_hi)) begin
                r_out_val <= r_last_val;
            end else begin
                r_out_val <= interp_val;
            end
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.result_value = r_out_val;
    assign o_out.below_range  = r_out_below;
    assign o_out.above_range  = r_out_above;

    assign o_status.need_interp = need_interp;
    assign o_status.out_busy    = r_out_valid && !o_out.ready;

endmodule

// ===== hdl/piecewise_linear_table_interp_core.sv =====
// Top level of the piecewise-linear table interpolator.
//
//  channel  | dir | handshake         | payload
//  ---------+-----+-------------------+---------------------------------------------------
//  i_in     | in  | valid/ready       | op, entry_index, entry_key, entry_value, query_key
//  o_out    | out | valid/ready       | result_value, below_range, above_range
//  cfg      | in  | i_cfg_we          | i_cfg_wdata = entry_count
//
//  Load beats go straight into the table and can follow each other every cycle when idle.
//  A query reads the table once per live entry; a clamped or matched result is then loaded,
//  while an interpolated one first passes the differences, a multiply and a 33-step divide.
//  The result register lets the next beat in while a result waits on o_out.ready.
//  Reset is synchronous and active low; the table contents are not cleared.
module piecewise_linear_table_interp_core import plti_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CNT_W-1:0] i_cfg_wdata,
    plti_in_if.sink          i_in,
    plti_out_if.source       o_out
);

    t_cmd    cmd;
    t_status status;

    plti_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (i_in),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    plti_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_entry_index (i_in.entry_index),
        .i_entry_key   (i_in.entry_key),
        .i_entry_value (i_in.entry_value),
        .i_query_key   (i_in.query_key),
        .o_status      (status),
        .o_out         (o_out)
    );

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |-> !status.out_busy)
        else $error("result register overwritten while held");

    a_busy_no_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.div_step |-> !i_in.ready)
        else $error("input accepted during a divide");

    a_valid_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out.valid) |-> $past(cmd.out_load))
        else $error("result valid without a result load");

    a_load_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready && i_in.op == OP_LOAD) |-> !cmd.out_load)
        else $error("load beat produced a result");

endmodule
